/* design/tcpq_pkg.sv */
// types, constants and field layouts shared by the two-class priority queue
// no dependencies; used by tcpq_core and two_class_priority_queue
package tcpq_pkg;

  // field widths fixed by the item layout
  localparam int ID_W   = 16;
  localparam int AGE_W  = 8;
  localparam int CNT_W  = 6;
  localparam int WORD_W = ID_W + AGE_W;

  // default store depth and register reset values
  localparam int          DEPTH_DEFAULT  = 32;
  localparam logic [5:0]  CAP_RESET      = 6'd20;
  localparam logic [7:0]  PRIO_AGE_RESET = 8'd65;

  // configuration register indexes
  localparam logic [0:0] REG_CAPACITY     = 1'b0;
  localparam logic [0:0] REG_PRIORITY_AGE = 1'b1;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] capacity;
    logic [AGE_W-1:0] priority_age;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  entry_id;
    logic [AGE_W-1:0] entry_age;
    logic             is_priority;
    logic [CNT_W-1:0] occupancy;
  } result_t;

endpackage

/* design/tcpq_ram.sv */
// simple dual-port store: one write port, one registered read port
// depends on nothing; instantiated by tcpq_core for each class
module tcpq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tcpq_core.sv */
// queue engine: head/tail pointers, counts, id counter and the two class stores
// depends on tcpq_pkg and tcpq_ram
module tcpq_core #(
  parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tcpq_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic                        in_func,
  input  logic [tcpq_pkg::AGE_W-1:0]  in_age,
  output logic                        busy,
  output logic                        res_valid,
  output tcpq_pkg::result_t           res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [tcpq_pkg::CNT_W-1:0] DEPTH_CAP =
    tcpq_pkg::CNT_W'((DEPTH < 64) ? DEPTH : 63);

  logic [PTR_W-1:0]           p_head, p_tail, n_head, n_tail;
  logic [tcpq_pkg::CNT_W-1:0] p_cnt, n_cnt;
  logic [tcpq_pkg::ID_W-1:0]  next_id;
  logic                       rd_pend;
  logic                       rd_prio;
  logic [tcpq_pkg::CNT_W-1:0] rd_occ;

  logic [tcpq_pkg::CNT_W-1:0]  total, limit;
  logic                        enq, deq, full, age_prio;
  logic                        push_p, push_n, pop_any, pop_p, pop_n;
  logic [tcpq_pkg::ID_W-1:0]   id_new;
  logic [tcpq_pkg::WORD_W-1:0] wword, p_rdata, n_rdata, rword;

  // decode the item and the occupancy limit
  always_comb begin
    enq      = in_valid && (in_func == tcpq_pkg::FUNC_ENQ);
    deq      = in_valid && (in_func == tcpq_pkg::FUNC_DEQ);
    total    = p_cnt + n_cnt;
    limit    = (cfg.capacity > DEPTH_CAP) ? DEPTH_CAP : cfg.capacity;
    full     = total >= limit;
    age_prio = in_age >= cfg.priority_age;
    push_p   = enq && !full && age_prio;
    push_n   = enq && !full && !age_prio;
    pop_any  = deq && (total != '0);
    pop_p    = pop_any && (p_cnt != '0);
    pop_n    = pop_any && (p_cnt == '0);
    id_new   = next_id + tcpq_pkg::ID_W'(1);
    wword    = {id_new, in_age};
  end

  tcpq_ram #(.DEPTH(DEPTH), .WIDTH(tcpq_pkg::WORD_W)) u_p_ram (
    .clk   (clk),
    .we    (push_p),
    .waddr (p_tail),
    .wdata (wword),
    .re    (pop_p),
    .raddr (p_head),
    .rdata (p_rdata)
  );

  tcpq_ram #(.DEPTH(DEPTH), .WIDTH(tcpq_pkg::WORD_W)) u_n_ram (
    .clk   (clk),
    .we    (push_n),
    .waddr (n_tail),
    .wdata (wword),
    .re    (pop_n),
    .raddr (n_head),
    .rdata (n_rdata)
  );

  // pointers, counts and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      p_head  <= '0;
      p_tail  <= '0;
      n_head  <= '0;
      n_tail  <= '0;
      p_cnt   <= '0;
      n_cnt   <= '0;
      next_id <= '0;
    end else begin
      if (push_p) begin
        p_tail <= (p_tail == PTR_LAST) ? '0 : p_tail + PTR_W'(1);
        p_cnt  <= p_cnt + tcpq_pkg::CNT_W'(1);
      end else if (pop_p) begin
        p_head <= (p_head == PTR_LAST) ? '0 : p_head + PTR_W'(1);
        p_cnt  <= p_cnt - tcpq_pkg::CNT_W'(1);
      end
      if (push_n) begin
        n_tail <= (n_tail == PTR_LAST) ? '0 : n_tail + PTR_W'(1);
        n_cnt  <= n_cnt + tcpq_pkg::CNT_W'(1);
      end else if (pop_n) begin
        n_head <= (n_head == PTR_LAST) ? '0 : n_head + PTR_W'(1);
        n_cnt  <= n_cnt - tcpq_pkg::CNT_W'(1);
      end
      if (push_p || push_n) begin
        next_id <= id_new;
      end
    end
  end

  // dequeue waits for the registered store read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= pop_any;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_any) begin
      rd_prio <= pop_p;
      rd_occ  <= total - tcpq_pkg::CNT_W'(1);
    end
  end

  // result select: read return or immediate answer
  always_comb begin
    rword     = rd_prio ? p_rdata : n_rdata;
    busy      = rd_pend;
    res_valid = rd_pend || enq || (deq && !pop_any);
    res       = '0;
    if (rd_pend) begin
      res.status      = tcpq_pkg::ST_DEQUEUED;
      res.entry_id    = rword[tcpq_pkg::WORD_W-1:tcpq_pkg::AGE_W];
      res.entry_age   = rword[tcpq_pkg::AGE_W-1:0];
      res.is_priority = rd_prio;
      res.occupancy   = rd_occ;
    end else if (enq && !full) begin
      res.status      = tcpq_pkg::ST_ENQUEUED;
      res.entry_id    = id_new;
      res.entry_age   = in_age;
      res.is_priority = age_prio;
      res.occupancy   = total + tcpq_pkg::CNT_W'(1);
    end else if (enq) begin
      res.status      = tcpq_pkg::ST_FULL;
      res.occupancy   = total;
    end else begin
      res.status      = tcpq_pkg::ST_EMPTY;
      res.occupancy   = total;
    end
  end

  // no item may arrive while a store read is outstanding
  a_no_accept_during_read: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !rd_pend)
    else $error("item accepted during store read");

  // a pending read always stems from a dequeue of a non-empty queue
  a_read_from_dequeue: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(in_valid && (in_func == tcpq_pkg::FUNC_DEQ) && (total != '0)))
    else $error("store read without dequeue");

  // a served dequeue removes exactly one entry
  a_dequeue_count: assert property (@(posedge clk) disable iff (rst)
    pop_any |=> (total == tcpq_pkg::CNT_W'($past(total) - tcpq_pkg::CNT_W'(1))))
    else $error("dequeue count mismatch");

  // a class count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (int'(p_cnt) <= DEPTH) && (int'(n_cnt) <= DEPTH))
    else $error("class count above depth");

endmodule

/* design/two_class_priority_queue.sv */
// two-class strict-priority queue: config registers, queue core and output buffer
// depends on tcpq_pkg and tcpq_core
// a served dequeue result goes via the store read register and the output buffer,
// others via the output buffer alone; one item per cycle, except during a served
// dequeue's store read or while two results wait, but not while one result waits
// sync reset: pointers, counts, id, buffer cleared; capacity 20, priority age 65
module two_class_priority_queue #(
  parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] age
  input  logic        s_tuser,   // [0] func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] entry_id, [23:16] entry_age,
                                 // [24] is_priority, [30:25] occupancy, [31] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tcpq_pkg::cfg_t    cfg;
  tcpq_pkg::result_t res, out_data, skid_data;
  logic              res_valid, busy;
  logic              out_valid, skid_valid, take, accept;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity     <= tcpq_pkg::CAP_RESET;
      cfg.priority_age <= tcpq_pkg::PRIO_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcpq_pkg::REG_CAPACITY:     cfg.capacity     <= cfg_data[5:0];
        tcpq_pkg::REG_PRIORITY_AGE: cfg.priority_age <= cfg_data;
      endcase
    end
  end

  // input handshake: room for the item's result and no read in flight
  assign s_tready = !busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;

  tcpq_core #(.DEPTH(DEPTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (accept),
    .in_func   (s_tuser),
    .in_age    (s_tdata),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-slot output buffer
  assign take = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid_data;
        skid_valid <= res_valid;
        if (res_valid) begin
          skid_data <= res;
        end
      end
    end else if (out_valid && !take) begin
      if (res_valid) begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_data <= res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_data.status;
  assign m_tdata  = {1'b0, out_data.occupancy, out_data.is_priority,
                     out_data.entry_age, out_data.entry_id};

  // skid slot is only used behind a full output slot
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot filled ahead of output slot");

  // a result never arrives when both slots are held
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!skid_valid || take))
    else $error("result buffer overflow");

  // a result follows every accepted item, at once or after the store read
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> (res_valid ##1 1'b1) or (1'b1 ##1 res_valid))
    else $error("accepted item produced no result");

endmodule
